// ===== hw/rtl/efcr_pkg.sv =====
`timescale 1ns / 1ps

package efcr_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int HEAD_DEPTH  = 4;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] FLAG_BYTE = 8'h7F;
    localparam logic [7:0] ESC_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] CHR_P     = 8'h70;
    localparam logic [7:0] CHR_O     = 8'h6F;
    localparam logic [7:0] CHR_S     = 8'h73;

    typedef enum logic [2:0] {
        KIND_YAW          = 3'd0,
        KIND_PITCH        = 3'd1,
        KIND_STOP         = 3'd2,
        KIND_MALFORMED    = 3'd3,
        KIND_UNRECOGNIZED = 3'd4,
        KIND_POLL         = 3'd5
    } t_kind;

    typedef struct packed {
        logic                          is_poll;
        logic                          poll_p;
        logic                          bad;
        logic                          short_frame;
        logic [HEAD_DEPTH-1:0][7:0]    head;
    } t_cmd;

endpackage

// ===== hw/rtl/efcr_front.sv =====
`timescale 1ns / 1ps

module efcr_front
    import efcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_req_type,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic                       r_in_frame, n_in_frame;
    logic                       r_esc, n_esc;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_toggle, n_toggle;
    logic [HEAD_DEPTH-1:0][7:0] r_head;

    logic       store;
    logic [7:0] store_byte;
    logic       is_flag;

    assign is_flag = (i_rx_byte == FLAG_BYTE);

    always_comb begin
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_cnt      = r_cnt;
        n_toggle   = r_toggle;
        store      = 1'b0;
        store_byte = i_rx_byte;
        o_push     = 1'b0;

        o_cmd.is_poll     = i_req_type;
        o_cmd.poll_p      = r_toggle;
        o_cmd.bad         = r_esc || (r_cnt > CNT_W'(FRAME_BYTES - 1));
        o_cmd.short_frame = (r_cnt < CNT_W'(HEAD_DEPTH));
        o_cmd.head        = r_head;

        if (i_accept) begin
            if (i_req_type) begin
                o_push   = 1'b1;
                n_toggle = ~r_toggle;
            end else if (is_flag) begin
                o_push     = r_in_frame && ((r_cnt != '0) || r_esc);
                n_in_frame = 1'b1;
                n_esc      = 1'b0;
                n_cnt      = '0;
            end else if (r_in_frame) begin
                if (r_esc) begin
                    store      = 1'b1;
                    store_byte = i_rx_byte ^ ESC_XOR;
                    n_esc      = 1'b0;
                end else if (i_rx_byte == ESC_BYTE) begin
                    n_esc = 1'b1;
                end else begin
                    store = 1'b1;
                end
            end
        end

        if (store && (r_cnt < CNT_W'(FRAME_BYTES))) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_cnt      <= '0;
            r_toggle   <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_cnt      <= n_cnt;
            r_toggle   <= n_toggle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store && (r_cnt < CNT_W'(HEAD_DEPTH))) begin
            r_head[r_cnt[1:0]] <= store_byte;
        end
    end

endmodule

// ===== hw/rtl/efcr_queue.sv =====
`timescale 1ns / 1ps

module efcr_queue
    import efcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_not_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full      = (r_count == QCNT_W'(QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/efcr_back.sv =====
`timescale 1ns / 1ps

module efcr_back
    import efcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_not_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_value
);

    logic        r_valid, n_valid;
    t_kind       r_kind, n_kind;
    logic [15:0] r_value, n_value;

    t_kind       dec_kind;
    logic [15:0] dec_value;

    always_comb begin
        dec_kind  = KIND_MALFORMED;
        dec_value = '0;
        if (i_cmd.is_poll) begin
            dec_kind  = KIND_POLL;
            dec_value = {8'h00, (i_cmd.poll_p ? CHR_P : CHR_O)};
        end else if (i_cmd.bad) begin
            dec_kind = KIND_MALFORMED;
        end else if (i_cmd.head[0] == CHR_S) begin
            dec_kind = KIND_STOP;
        end else if ((i_cmd.head[0] != CHR_P) && (i_cmd.head[0] != CHR_O)) begin
            dec_kind = KIND_UNRECOGNIZED;
        end else if (i_cmd.short_frame || (i_cmd.head[1] != i_cmd.head[0])) begin
            dec_kind = KIND_MALFORMED;
        end else begin
            dec_kind  = (i_cmd.head[0] == CHR_P) ? KIND_YAW : KIND_PITCH;
            dec_value = {i_cmd.head[2], i_cmd.head[3]};
        end
    end

    assign o_pop = i_not_empty && (!r_valid || !i_stall);

    always_comb begin
        n_valid = r_valid;
        n_kind  = r_kind;
        n_value = r_value;
        if (o_pop) begin
            n_valid = 1'b1;
            n_kind  = dec_kind;
            n_value = dec_value;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
    end

    assign o_valid       = r_valid;
    assign o_result_kind = r_kind;
    assign o_value       = r_value;

endmodule

// ===== hw/rtl/escaped_frame_command_receiver.sv =====
// channel  | signals                                  | direction
// ---------+------------------------------------------+----------
// request  | i_valid, o_stall, i_req_type, i_rx_byte  | in
// result   | o_valid, i_stall, o_result_kind, o_value | out
//
// one beat accepted per cycle while o_stall is low; a result passes from the beat
// causing it through the command queue and then the result register to the outputs
// a four-entry command queue separates the deframer from the result register
// o_stall rises only when that queue is full
// reset is synchronous on i_rst_n
`timescale 1ns / 1ps

module escaped_frame_command_receiver
    import efcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_value
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic not_empty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    efcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    efcr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .i_pop       (pop),
        .o_full      (full),
        .o_not_empty (not_empty),
        .o_cmd       (queue_cmd)
    );

    efcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_not_empty   (not_empty),
        .i_cmd         (queue_cmd),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_value       (o_value)
    );

endmodule

// ===== hw/rtl/efcr_checker.sv =====
`timescale 1ns / 1ps

module efcr_checker
    import efcr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_req_type,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_result_kind,
    input logic [15:0] o_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) && $stable(o_value))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_poll_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_POLL)
            |-> (o_value == {8'h00, CHR_O}) || (o_value == {8'h00, CHR_P}))
        else $error("poll beat carries a bad character");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_result_kind == KIND_STOP) || (o_result_kind == KIND_MALFORMED)
            || (o_result_kind == KIND_UNRECOGNIZED)) |-> (o_value == '0))
        else $error("nonzero value on a valueless result");

    a_poll_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_req_type && !o_valid |-> ##2 o_valid)
        else $error("accepted poll tick did not reach an empty output");

endmodule

bind escaped_frame_command_receiver efcr_checker u_efcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_req_type    (i_req_type),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_kind (o_result_kind),
    .o_value       (o_value)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import efcr_pkg::*;

    bit          i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_result_kind;
    logic [15:0] o_value;

    escaped_frame_command_receiver i_dut (.*);

    typedef struct {
        t_kind       kind;
        logic [15:0] val;
    } cmd_result_t;

    typedef struct {
        logic        req;
        logic [7:0]  rx;
        logic        typed;
        logic        got;
        t_kind       kind;
        logic [15:0] val;
    } beat_row_t;

    localparam int DIR_ROWS   = 25;
    localparam int PHASE_BEATS = 575;

    // typed rows carry their own expectation, the rest go through the predictor
    beat_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{1'b0, 8'h00,     1'b1, 1'b0, KIND_YAW,          16'h0000},
        '{1'b1, 8'h00,     1'b1, 1'b1, KIND_POLL,         {8'h00, CHR_O}},
        '{1'b1, 8'hFF,     1'b1, 1'b1, KIND_POLL,         {8'h00, CHR_P}},
        '{1'b0, FLAG_BYTE, 1'b1, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, FLAG_BYTE, 1'b1, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, CHR_P,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, CHR_P,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, 8'hFF,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, 8'hFF,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, FLAG_BYTE, 1'b1, 1'b1, KIND_YAW,          16'hFFFF},
        '{1'b0, CHR_O,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, CHR_O,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, ESC_BYTE,  1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, 8'h5F,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, ESC_BYTE,  1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, 8'h5E,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, FLAG_BYTE, 1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, CHR_S,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, FLAG_BYTE, 1'b1, 1'b1, KIND_STOP,         16'h0000},
        '{1'b0, 8'h00,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, FLAG_BYTE, 1'b1, 1'b1, KIND_UNRECOGNIZED, 16'h0000},
        '{1'b0, ESC_BYTE,  1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, FLAG_BYTE, 1'b1, 1'b1, KIND_MALFORMED,    16'h0000},
        '{1'b0, CHR_P,     1'b0, 1'b0, KIND_YAW,          16'h0000},
        '{1'b0, FLAG_BYTE, 1'b1, 1'b1, KIND_MALFORMED,    16'h0000}
    };

    int snd_idle [3] = '{7, 86, 0};
    int rcv_idle [3] = '{86, 7, 0};

    // deframer state of the predictor
    logic       fr_open;
    logic       esc_hold;
    logic [6:0] byte_cnt;
    logic [7:0] head_q [HEAD_DEPTH];
    logic       poll_next_p;

    cmd_result_t pending_res [$];
    beat_row_t   cur_row;
    int          fail_cnt;
    int          beats_sent;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void note_fail(string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void deframe_beat(input logic req, input logic [7:0] b,
                                         output logic got, output t_kind kind,
                                         output logic [15:0] val);
        logic [7:0] d;
        got  = 1'b0;
        kind = KIND_YAW;
        val  = 16'h0000;
        if (req) begin
            got         = 1'b1;
            kind        = KIND_POLL;
            val         = {8'h00, poll_next_p ? CHR_P : CHR_O};
            poll_next_p = ~poll_next_p;
        end else if (b == FLAG_BYTE) begin
            if (fr_open && (byte_cnt != 0 || esc_hold)) begin
                got = 1'b1;
                if (esc_hold || byte_cnt > FRAME_BYTES - 1) begin
                    kind = KIND_MALFORMED;
                end else if (head_q[0] == CHR_S) begin
                    kind = KIND_STOP;
                end else if (head_q[0] != CHR_P && head_q[0] != CHR_O) begin
                    kind = KIND_UNRECOGNIZED;
                end else if (byte_cnt < HEAD_DEPTH || head_q[1] != head_q[0]) begin
                    kind = KIND_MALFORMED;
                end else begin
                    kind = (head_q[0] == CHR_P) ? KIND_YAW : KIND_PITCH;
                    val  = {head_q[2], head_q[3]};
                end
            end
            fr_open  = 1'b1;
            esc_hold = 1'b0;
            byte_cnt = '0;
        end else if (fr_open) begin
            if (!esc_hold && b == ESC_BYTE) begin
                esc_hold = 1'b1;
            end else begin
                d        = esc_hold ? (b ^ ESC_XOR) : b;
                esc_hold = 1'b0;
                if (byte_cnt < HEAD_DEPTH) begin
                    head_q[byte_cnt[1:0]] = d;
                end
                if (byte_cnt < FRAME_BYTES) begin
                    byte_cnt++;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        cmd_result_t want;
        logic        got;
        t_kind       k;
        logic [15:0] v;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_res.size() == 0) begin
                    note_fail($sformatf("unexpected result: kind %0d value %h",
                                        o_result_kind, o_value));
                end else begin
                    want = pending_res.pop_front();
                    if (o_result_kind !== want.kind || o_value !== want.val) begin
                        note_fail($sformatf({"result mismatch: expected kind %0d value %h,",
                                             " got kind %0d value %h"},
                                            want.kind, want.val, o_result_kind, o_value));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                deframe_beat(i_req_type, i_rx_byte, got, k, v);
                if (cur_row.typed) begin
                    got = cur_row.got;
                    k   = cur_row.kind;
                    v   = cur_row.val;
                end
                if (got) begin
                    pending_res.push_back('{k, v});
                end
            end
        end
    end

    task automatic push_beat(input beat_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= row.req;
        i_rx_byte  <= row.rx;
        cur_row    <= row;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // random poll ticks fall between bytes, even inside an escape
    task automatic send_raw(input logic [7:0] b);
        if ($urandom_range(99) < 6) begin
            push_beat('{1'b1, 8'($urandom_range(255)), 1'b0, 1'b0, KIND_YAW, 16'h0000});
        end
        push_beat('{1'b0, b, 1'b0, 1'b0, KIND_YAW, 16'h0000});
    endtask

    task automatic send_data(input logic [7:0] d);
        if (d == FLAG_BYTE || d == ESC_BYTE ||
            (d != (FLAG_BYTE ^ ESC_XOR) && $urandom_range(7) == 0)) begin
            send_raw(ESC_BYTE);
            send_raw(d ^ ESC_XOR);
        end else begin
            send_raw(d);
        end
    endtask

    task automatic send_frame();
        int         sel;
        int         n;
        logic [7:0] lead;
        logic [7:0] b;
        sel  = $urandom_range(99);
        lead = $urandom_range(1) ? CHR_P : CHR_O;
        if (sel < 40) begin
            send_data(lead);
            send_data(lead);
            send_data(8'($urandom_range(255)));
            send_data(8'($urandom_range(255)));
            n = ($urandom_range(3) == 0) ? $urandom_range(FRAME_BYTES - 1 - HEAD_DEPTH) : 0;
            repeat (n) send_data(8'($urandom_range(255)));
        end else if (sel < 50) begin
            send_data(CHR_S);
            repeat ($urandom_range(FRAME_BYTES - 2)) send_data(8'($urandom_range(255)));
        end else if (sel < 58) begin
            b = 8'($urandom_range(255));
            if (b == lead) begin
                b = ~b;
            end
            send_data(lead);
            send_data(b);
            send_data(8'($urandom_range(255)));
            send_data(8'($urandom_range(255)));
        end else if (sel < 65) begin
            send_data(lead);
            repeat ($urandom_range(2)) send_data(lead);
        end else if (sel < 72) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(140, 100)
                                         : $urandom_range(FRAME_BYTES + 4, FRAME_BYTES);
            send_data(($urandom_range(2) == 0) ? CHR_S : lead);
            send_data(lead);
            repeat (n - 2) send_data(8'($urandom_range(255)));
        end else if (sel < 80) begin
            send_data(8'($urandom_range(255)));
            repeat ($urandom_range(FRAME_BYTES - 2)) send_data(8'($urandom_range(255)));
        end else if (sel < 86) begin
            repeat ($urandom_range(5)) send_data(8'($urandom_range(255)));
            send_raw(ESC_BYTE);
        end else if (sel < 93) begin
            repeat ($urandom_range(8, 1)) send_raw(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(3, 1)) send_raw(FLAG_BYTE);
        end
        send_raw(FLAG_BYTE);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_res.size() != 0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = 1'b0;
        i_rx_byte     = 8'h00;
        i_stall       = 1'b0;
        cur_row       = '{1'b0, 8'h00, 1'b0, 1'b0, KIND_YAW, 16'h0000};
        fr_open       = 1'b0;
        esc_hold      = 1'b0;
        byte_cnt      = '0;
        poll_next_p   = 1'b0;
        fail_cnt      = 0;
        beats_sent    = 0;
        send_idle_pct = snd_idle[0];
        recv_idle_pct = rcv_idle[0];
        foreach (head_q[j]) head_q[j] = 8'h00;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            push_beat(dir_rows[r]);
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = snd_idle[ph];
            recv_idle_pct = rcv_idle[ph];
            while (beats_sent < DIR_ROWS + (ph + 1) * PHASE_BEATS) begin
                send_frame();
            end
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        fail_cnt += pending_res.size();
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
